@@ rtl/rxsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsh_pkg: shared types and constants
// Word width, name length limit, divider states and the hand-off records
// that pass between the front end, the hash queue and the reduction unit.
// ----------------------------------------------------------------------------
package rxsh_pkg;

    localparam int WORD_BITS = 64;
    localparam int MAX_CHARS = 32;
    localparam int ROT_STEP  = 2;
    localparam int ROT_LIMIT = WORD_BITS - 8;

    localparam int ROT_W = $clog2(WORD_BITS);
    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam int STEP_W = $clog2(WORD_BITS);

    localparam int TS_W     = 17;
    localparam int BUCKET_W = 16;
    localparam logic [TS_W-1:0] TS_RESET = TS_W'(1024);
    localparam logic [TS_W-1:0] TS_MAX   = TS_W'(65536);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef logic [WORD_BITS-1:0] hash_word_t;

    typedef struct packed {
        logic       valid;
        hash_word_t hash;
    } hash_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_OUTPUT
    } back_state_t;

endpackage

@@ rtl/rxsh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsh_front: byte intake and rotating XOR accumulation
// Folds one byte per cycle while the queue has room into the running word
// of each name and hands it to the hash queue on the byte marked last.
// ----------------------------------------------------------------------------
module rxsh_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_name_byte,
    input  logic                   s_is_last,
    input  rxsh_pkg::queue_status_t q_status,
    output rxsh_pkg::hash_push_t    q_push
);
    import rxsh_pkg::*;

    hash_word_t       hash_reg, hash_next;
    logic [ROT_W-1:0] rot_reg, rot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ended_reg, ended_next;

    logic             accept;
    logic             take;
    hash_word_t       hash_upd;
    logic [ROT_W:0]   rot_sum;
    logic [ROT_W-1:0] rot_upd;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        take     = !ended_reg && (cnt_reg < CNT_W'(MAX_CHARS)) && (s_name_byte != 8'd0);
        rot_sum  = {1'b0, rot_reg} + (ROT_W + 1)'(ROT_STEP);
        rot_upd  = (rot_sum >= (ROT_W + 1)'(ROT_LIMIT)) ? '0 : rot_sum[ROT_W-1:0];
        hash_upd = hash_reg ^ (WORD_BITS'(s_name_byte) << rot_reg);

        hash_next  = hash_reg;
        rot_next   = rot_reg;
        cnt_next   = cnt_reg;
        ended_next = ended_reg;
        if (take) begin
            hash_next = hash_upd;
            rot_next  = rot_upd;
            cnt_next  = cnt_reg + CNT_W'(1);
        end else if (!ended_reg && cnt_reg < CNT_W'(MAX_CHARS)) begin
            ended_next = 1'b1;
        end

        q_push.valid = accept && s_is_last;
        q_push.hash  = take ? hash_upd : hash_reg;

        if (!accept) begin
            hash_next  = hash_reg;
            rot_next   = rot_reg;
            cnt_next   = cnt_reg;
            ended_next = ended_reg;
        end else if (s_is_last) begin
            // clear per-name state once the word is queued
            hash_next  = '0;
            rot_next   = '0;
            cnt_next   = '0;
            ended_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= '0;
            rot_reg   <= '0;
            cnt_reg   <= '0;
            ended_reg <= 1'b0;
        end else begin
            hash_reg  <= hash_next;
            rot_reg   <= rot_next;
            cnt_reg   <= cnt_next;
            ended_reg <= ended_next;
        end
    end

endmodule

@@ rtl/rxsh_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsh_queue: short queue of finished hash words
// Decouples byte intake from the reduction unit so each side stalls alone.
// ----------------------------------------------------------------------------
module rxsh_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rxsh_pkg::hash_push_t    push,
    input  logic                    pop,
    output rxsh_pkg::hash_word_t    head,
    output rxsh_pkg::queue_status_t status
);
    import rxsh_pkg::*;

    hash_word_t     entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign status.full  = (count_reg == QCW'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCW'(1);
            2'b01:   count_next = count_reg - QCW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.hash;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !status.full)
        else $error("hash queue overflow");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("hash queue underflow");

endmodule

@@ rtl/rxsh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxsh_back: bucket reduction unit
// Reduces each queued word modulo the table size with a restoring divider,
// one dividend bit per cycle, and holds the bucket in an output register.
// ----------------------------------------------------------------------------
module rxsh_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rxsh_pkg::TS_W-1:0]     table_size,
    input  rxsh_pkg::queue_status_t       q_status,
    input  rxsh_pkg::hash_word_t          q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rxsh_pkg::BUCKET_W-1:0] m_bucket
);
    import rxsh_pkg::*;

    back_state_t         state_reg, state_next;
    hash_word_t          dvd_reg, dvd_next;
    logic [BUCKET_W-1:0] rem_reg, rem_next;
    logic [TS_W-1:0]     div_reg, div_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic [BUCKET_W-1:0] out_bucket_reg, out_bucket_next;

    logic [TS_W-1:0] div_clamped;
    logic [TS_W-1:0] trial;
    logic [TS_W-1:0] trial_sub;

    assign m_valid  = out_valid_reg;
    assign m_bucket = out_bucket_reg;

    always_comb begin
        if (table_size == '0) begin
            div_clamped = TS_W'(1);
        end else if (table_size > TS_MAX) begin
            div_clamped = TS_MAX;
        end else begin
            div_clamped = table_size;
        end

        trial     = {rem_reg, dvd_reg[WORD_BITS-1]};
        trial_sub = trial - div_reg;

        state_next      = state_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        out_bucket_next = out_bucket_reg;
        q_pop           = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    dvd_next   = q_head;
                    rem_next   = '0;
                    div_next   = div_clamped;
                    step_next  = '0;
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE: begin
                // shift in one dividend bit, subtract when it fits
                dvd_next = dvd_reg << 1;
                rem_next = (trial >= div_reg) ? trial_sub[BUCKET_W-1:0]
                                              : trial[BUCKET_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(WORD_BITS - 1)) begin
                    state_next = BK_OUTPUT;
                end
            end
            BK_OUTPUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_bucket_next = rem_reg;
                    state_next      = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        step_reg       <= step_next;
        out_bucket_reg <= out_bucket_next;
    end

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIVIDE || state_reg == BK_OUTPUT) |-> ({1'b0, rem_reg} < div_reg))
        else $error("partial remainder not below divisor");

    a_pop_starts_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == BK_DIVIDE && step_reg == '0))
        else $error("queue pop did not start a division");

    a_load_only_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == BK_OUTPUT)
        else $error("bucket loaded outside the output step");

endmodule

@@ rtl/rotating_xor_string_bucket_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotating_xor_string_bucket_hash: rotating XOR name hash to bucket index
// Bytes are accepted one per cycle while the hash queue has room; each name
// is reduced modulo table_size by a bit-serial divider behind the queue.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue has room; the divider takes
//   one dividend bit per cycle, a name at a time, with two names queued.
// Reset: aresetn synchronous active low; clears the per-name state, the
//   queue and the output, and sets table_size to 1024.
module rotating_xor_string_bucket_hash (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rxsh_pkg::PADDR_W-1:0]          paddr,
    input  logic [rxsh_pkg::PDATA_W-1:0]          pwdata,
    output logic [rxsh_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_name_byte,
    input  logic                                  s_is_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [rxsh_pkg::BUCKET_W-1:0]         m_bucket
);
    import rxsh_pkg::*;

    logic [TS_W-1:0] table_size_reg, table_size_next;
    logic            reg_hit;

    hash_push_t    q_push;
    queue_status_t q_status;
    hash_word_t    q_head;
    logic          q_pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_TABLE_SIZE);

    always_comb begin
        table_size_next = table_size_reg;
        if (psel && penable && pwrite && reg_hit) begin
            table_size_next = pwdata[TS_W-1:0];
        end
        prdata = reg_hit ? PDATA_W'(table_size_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TS_RESET;
        end else begin
            table_size_reg <= table_size_next;
        end
    end

    rxsh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_name_byte (s_name_byte),
        .s_is_last   (s_is_last),
        .q_status    (q_status),
        .q_push      (q_push)
    );

    rxsh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .pop     (q_pop),
        .head    (q_head),
        .status  (q_status)
    );

    rxsh_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .table_size (table_size_reg),
        .q_status   (q_status),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_bucket   (m_bucket)
    );

endmodule
